// ----- hw/rtl/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned CNT_W        = 32;
  localparam int unsigned IN_ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 5;
  localparam int unsigned SET_BITS_W   = 4;
  localparam int unsigned OFF_BITS_W   = 5;
  localparam int unsigned WAYS_W       = 4;
  localparam int unsigned OFFSET_MAX   = 20;
  localparam int unsigned SHIFT_W      = 7;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
  localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  typedef enum logic [1:0] {
    OP_FETCH  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STORE  = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic     hit;
    logic     evict;
    outcome_e outcome;
  } lookup_t;

endpackage

// ----- hw/rtl/lct_set_ram.sv -----
// ----------------------------------------------------------------------------
// lct_set_ram
// One row per set holding valid bits, tags and LRU ranks of all ways.
// Synchronous read with registered data; sweeps all rows to zero after reset.
// ----------------------------------------------------------------------------
module lct_set_ram #(
  parameter int unsigned SET_BITS = 10,
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_W    = 30,
  parameter int unsigned RANK_W   = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [SET_BITS-1:0]              rd_addr_i,
  output logic [WAYS-1:0]                  rd_valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]       rd_tag_o,
  output logic [WAYS-1:0][RANK_W-1:0]      rd_rank_o,
  input  logic                             wr_en_i,
  input  logic [SET_BITS-1:0]              wr_addr_i,
  input  logic [WAYS-1:0]                  wr_valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]       wr_tag_i,
  input  logic [WAYS-1:0][RANK_W-1:0]      wr_rank_i,
  output logic                             clear_done_o
);

  localparam int unsigned NUM_SETS = 1 << SET_BITS;
  localparam int unsigned ROW_W    = WAYS * (1 + TAG_W + RANK_W);

  logic [ROW_W-1:0] mem_q [NUM_SETS];
  logic [ROW_W-1:0] rd_q;
  logic [SET_BITS:0] clr_q;
  logic [SET_BITS:0] clr_d;
  logic              clr_active;

  assign clr_active   = ~clr_q[SET_BITS];
  assign clear_done_o = clr_q[SET_BITS];
  assign clr_d        = clr_q + (SET_BITS+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_active) begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active) begin
      mem_q[clr_q[SET_BITS-1:0]] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_valid_i, wr_tag_i, wr_rank_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign {rd_valid_o, rd_tag_o, rd_rank_o} = rd_q;

endmodule

// ----- hw/rtl/lct_update.sv -----
// ----------------------------------------------------------------------------
// lct_update
// Tag compare over the in-use ways of one set, fill or LRU victim choice,
// and the rank update of the touched set row.
// ----------------------------------------------------------------------------
module lct_update #(
  parameter int unsigned WAYS   = 8,
  parameter int unsigned TAG_W  = 30,
  parameter int unsigned RANK_W = 3,
  parameter int unsigned WW     = 4
) (
  input  logic [WW-1:0]                ways_i,
  input  logic [TAG_W-1:0]             tag_i,
  input  logic [WAYS-1:0]              rd_valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]   rd_tag_i,
  input  logic [WAYS-1:0][RANK_W-1:0]  rd_rank_i,
  output logic [WAYS-1:0]              wr_valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]   wr_tag_o,
  output logic [WAYS-1:0][RANK_W-1:0]  wr_rank_o,
  output lct_pkg::lookup_t             lookup_o
);

  import lct_pkg::*;

  localparam int unsigned WI = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  logic [WAYS-1:0]   in_use;
  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   free;
  logic [WI-1:0]     hit_w;
  logic [WI-1:0]     free_w;
  logic [WI-1:0]     victim_w;
  logic [WI-1:0]     sel_w;
  logic [RANK_W-1:0] best;
  logic              found;
  logic              hit;
  logic              any_free;
  logic              was_valid;
  logic [RANK_W-1:0] old_rank;

  always_comb begin
    hit_w  = '0;
    free_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      in_use[i] = (WW'(i) < ways_i);
      match[i]  = in_use[i] & rd_valid_i[i] & (rd_tag_i[i] == tag_i);
      free[i]   = in_use[i] & ~rd_valid_i[i];
      if (match[i]) begin
        hit_w = WI'(i);
      end
      if (free[i]) begin
        free_w = WI'(i);
      end
    end
    hit      = |match;
    any_free = |free;

    best     = '0;
    found    = 1'b0;
    victim_w = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i] && (!found || rd_rank_i[i] > best)) begin
        best     = rd_rank_i[i];
        victim_w = WI'(i);
        found    = 1'b1;
      end
    end

    if (hit) begin
      sel_w = hit_w;
    end else if (any_free) begin
      sel_w = free_w;
    end else begin
      sel_w = victim_w;
    end
    was_valid = hit | ~any_free;
    old_rank  = rd_rank_i[sel_w];

    wr_valid_o = rd_valid_i;
    wr_tag_o   = rd_tag_i;
    wr_rank_o  = rd_rank_i;
    for (int i = 0; i < WAYS; i++) begin
      if (WI'(i) == sel_w) begin
        wr_valid_o[i] = 1'b1;
        wr_tag_o[i]   = tag_i;
        wr_rank_o[i]  = '0;
      end else if (in_use[i] && rd_valid_i[i] &&
                   (!was_valid || rd_rank_i[i] < old_rank) &&
                   rd_rank_i[i] < RANK_MAX) begin
        wr_rank_o[i] = rd_rank_i[i] + RANK_W'(1);
      end
    end

    lookup_o.hit   = hit;
    lookup_o.evict = ~hit & ~any_free;
    if (hit) begin
      lookup_o.outcome = OUT_HIT;
    end else if (any_free) begin
      lookup_o.outcome = OUT_FILL;
    end else begin
      lookup_o.outcome = OUT_EVICT;
    end
  end

endmodule

// ----- hw/rtl/lru_set_assoc_cache_tracker.sv -----
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tracker
// Set-associative cache tracker with true-LRU replacement and running totals.
// ----------------------------------------------------------------------------
// A load, store or modify item has its set row read from the set memory in the
// cycle it is accepted; in the lookup state the ways are compared and, once the
// output register is free, the row is written back and the result registered.
// The input is not ready during the lookup and takes the next item in the cycle
// after it. An instruction fetch gives no result. After reset the set memory is
// swept clear, one row a cycle, over all 2**MAX_SET_BITS rows (1024 by
// default), and the input becomes ready in the cycle after the sweep ends;
// configuration writes are taken at any time. A modify reports the outcome of
// its load part and counts one extra hit. Totals saturate at all ones.
module lru_set_assoc_cache_tracker #(
  parameter int unsigned MAX_SET_BITS = 10,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lct_pkg::op_e                  opcode_i,
  input  logic [lct_pkg::IN_ADDR_W-1:0] address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lct_pkg::outcome_e             outcome_o,
  output logic                          second_hit_o,
  output logic [lct_pkg::CNT_W-1:0]     hits_total_o,
  output logic [lct_pkg::CNT_W-1:0]     misses_total_o,
  output logic [lct_pkg::CNT_W-1:0]     evictions_total_o
);

  import lct_pkg::*;

  localparam int unsigned TAG_W  = ADDR_WIDTH - 2;
  localparam int unsigned RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SW     = $clog2(MAX_SET_BITS + 1);
  localparam int unsigned WW     = $clog2(MAX_WAYS + 1);

  state_e state_q, state_d;

  logic [SET_BITS_W-1:0] set_bits_q;
  logic [OFF_BITS_W-1:0] off_bits_q;
  logic [WAYS_W-1:0]     ways_q;

  logic [SW-1:0]           s_eff;
  logic [OFF_BITS_W-1:0]   b_eff;
  logic [WW-1:0]           ways_eff;
  logic [ADDR_WIDTH-1:0]   addr;
  logic [ADDR_WIDTH-1:0]   addr_shift;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [TAG_W-1:0]        tag_in;

  logic [MAX_SET_BITS-1:0] set_q;
  logic [TAG_W-1:0]        tag_q;
  logic                    modify_q;

  logic                    in_accept;
  logic                    rd_en;
  logic                    upd_en;
  logic                    clear_done;

  logic [MAX_WAYS-1:0]              rd_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   rd_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0]  rd_rank;
  logic [MAX_WAYS-1:0]              wr_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   wr_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0]  wr_rank;
  lookup_t                          lookup;

  logic               out_valid_q, out_valid_d;
  outcome_e           outcome_q;
  logic               second_q;
  logic [CNT_W-1:0]   hits_q, misses_q, evicts_q;
  logic [CNT_W:0]     hits_sum, misses_sum, evicts_sum;
  logic [1:0]         hit_inc;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= SET_BITS_RST;
      off_bits_q <= OFF_BITS_RST;
      ways_q     <= WAYS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_BITS: set_bits_q <= cfg_data_i[SET_BITS_W-1:0];
        CFG_OFF_BITS: off_bits_q <= cfg_data_i[OFF_BITS_W-1:0];
        CFG_WAYS:     ways_q     <= cfg_data_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp settings into their used ranges
  always_comb begin
    if (set_bits_q == '0) begin
      s_eff = SW'(1);
    end else if (32'(set_bits_q) > MAX_SET_BITS) begin
      s_eff = SW'(MAX_SET_BITS);
    end else begin
      s_eff = SW'(set_bits_q);
    end
    if (off_bits_q == '0) begin
      b_eff = OFF_BITS_W'(1);
    end else if (32'(off_bits_q) > OFFSET_MAX) begin
      b_eff = OFF_BITS_W'(OFFSET_MAX);
    end else begin
      b_eff = off_bits_q;
    end
    if (ways_q == '0) begin
      ways_eff = WW'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = WW'(MAX_WAYS);
    end else begin
      ways_eff = WW'(ways_q);
    end
  end

  // Address split
  assign addr       = ADDR_WIDTH'(address_i);
  assign addr_shift = addr >> b_eff;
  assign set_mask   = ~({MAX_SET_BITS{1'b1}} << s_eff);
  assign set_idx    = addr_shift[MAX_SET_BITS-1:0] & set_mask;
  assign tag_shift  = SHIFT_W'(b_eff) + SHIFT_W'(s_eff);
  assign tag_in     = TAG_W'(addr >> tag_shift);

  // Control
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign rd_en      = in_accept & (opcode_i != OP_FETCH);

  always_comb begin
    state_d = state_q;
    upd_en  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (rd_en) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_q || out_ready_i) begin
          upd_en  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q    <= set_idx;
      tag_q    <= tag_in;
      modify_q <= (opcode_i == OP_MODIFY);
    end
  end

  lct_set_ram #(
    .SET_BITS (MAX_SET_BITS),
    .WAYS     (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W)
  ) u_set_ram (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (set_idx),
    .rd_valid_o   (rd_valid),
    .rd_tag_o     (rd_tag),
    .rd_rank_o    (rd_rank),
    .wr_en_i      (upd_en),
    .wr_addr_i    (set_q),
    .wr_valid_i   (wr_valid),
    .wr_tag_i     (wr_tag),
    .wr_rank_i    (wr_rank),
    .clear_done_o (clear_done)
  );

  lct_update #(
    .WAYS   (MAX_WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W),
    .WW     (WW)
  ) u_update (
    .ways_i     (ways_eff),
    .tag_i      (tag_q),
    .rd_valid_i (rd_valid),
    .rd_tag_i   (rd_tag),
    .rd_rank_i  (rd_rank),
    .wr_valid_o (wr_valid),
    .wr_tag_o   (wr_tag),
    .wr_rank_o  (wr_rank),
    .lookup_o   (lookup)
  );

  // Saturating totals
  assign hit_inc    = {1'b0, lookup.hit} + {1'b0, modify_q};
  assign hits_sum   = {1'b0, hits_q} + (CNT_W+1)'(hit_inc);
  assign misses_sum = {1'b0, misses_q} + {{CNT_W{1'b0}}, ~lookup.hit};
  assign evicts_sum = {1'b0, evicts_q} + {{CNT_W{1'b0}}, lookup.evict};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (upd_en) begin
      hits_q   <= hits_sum[CNT_W]   ? '1 : hits_sum[CNT_W-1:0];
      misses_q <= misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
      evicts_q <= evicts_sum[CNT_W] ? '1 : evicts_sum[CNT_W-1:0];
    end
  end

  // Output register
  assign out_valid_d = upd_en | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      outcome_q <= lookup.outcome;
      second_q  <= modify_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign second_hit_o      = second_q;
  assign hits_total_o      = hits_q;
  assign misses_total_o    = misses_q;
  assign evictions_total_o = evicts_q;

endmodule

// ----- tb/sv/lru_set_assoc_cache_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_tracker_tb
// Self-checking bench for the LRU cache tracker. A behavioral cache model with
// per-set LRU ranks predicts the outcome and the running totals of every load,
// store and modify access. It runs a directed warm-up, then phases of random
// accesses over small tag and set pools under several geometries, with random
// gaps on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_tracker_tb;
  import lct_pkg::*;

  localparam int unsigned SET_BITS_MAX   = 10;
  localparam int unsigned WAYS_MAX       = 8;
  localparam int unsigned LINES          = (1 << SET_BITS_MAX) * WAYS_MAX;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ACCESSES = 160;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    op_e         op;
    logic [31:0] addr;
  } access_t;

  typedef struct packed {
    outcome_e    outcome;
    logic        second;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } access_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  op_e                   opcode_i;
  logic [IN_ADDR_W-1:0]  address_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  outcome_e              outcome_o;
  logic                  second_hit_o;
  logic [CNT_W-1:0]      hits_total_o;
  logic [CNT_W-1:0]      misses_total_o;
  logic [CNT_W-1:0]      evictions_total_o;

  lru_set_assoc_cache_tracker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .outcome_o        (outcome_o),
    .second_hit_o     (second_hit_o),
    .hits_total_o     (hits_total_o),
    .misses_total_o   (misses_total_o),
    .evictions_total_o(evictions_total_o)
  );

  // cache model state
  bit          line_ok   [LINES];
  logic [31:0] line_tag_q[LINES];
  int unsigned age_rank  [LINES];
  logic [31:0] hit_total, miss_total, evict_total;
  logic [3:0]  raw_set_bits, raw_ways;
  logic [4:0]  raw_off_bits;

  access_t        pending_accesses[$];
  access_report_t expected_reports[$];
  access_t        next_access;
  access_report_t got_report, want_report;

  int unsigned queued_count, sent_count, results_seen, fail_count;
  int unsigned fetch_count, hit_outcomes, fill_count, evict_count, settings_count;
  int unsigned send_gap, stall_left, long_hold_left, quiet_cycles, gap_draw;
  bit          held_once, no_idle;

  int unsigned phase_cfg[PHASES][3] = '{
    '{15, 31, 15}, '{0, 0, 0}, '{10, 20, 8}, '{1, 1, 8}, '{2, 6, 2},
    '{4, 5, 4}, '{3, 16, 3}, '{5, 2, 8}, '{1, 20, 5}, '{0, 4, 7}
  };

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void make_recent(int unsigned base, int unsigned nways, int unsigned w,
                                      bit was_valid);
    int unsigned old_rank;
    int unsigned i;
    old_rank = age_rank[base + w];
    for (i = 0; i < nways; i++) begin
      if (i != w && line_ok[base + i] && (!was_valid || age_rank[base + i] < old_rank) &&
          age_rank[base + i] < WAYS_MAX - 1)
        age_rank[base + i]++;
    end
    age_rank[base + w] = 0;
  endfunction

  function automatic outcome_e cache_access(logic [31:0] a);
    int unsigned s, b, nways, set_no, base, i, victim, best;
    logic [31:0] tg;
    s      = clamp_cfg(32'(raw_set_bits), 1, SET_BITS_MAX);
    b      = clamp_cfg(32'(raw_off_bits), 1, OFFSET_MAX);
    nways  = clamp_cfg(32'(raw_ways), 1, WAYS_MAX);
    set_no = (a >> b) & ((32'd1 << s) - 1);
    tg     = a >> (b + s);
    base   = set_no * WAYS_MAX;
    for (i = 0; i < nways; i++) begin
      if (line_ok[base + i] && line_tag_q[base + i] == tg) begin
        make_recent(base, nways, i, 1'b1);
        if (hit_total != '1) hit_total++;
        return OUT_HIT;
      end
    end
    if (miss_total != '1) miss_total++;
    for (i = 0; i < nways; i++) begin
      if (!line_ok[base + i]) begin
        make_recent(base, nways, i, 1'b0);
        line_ok[base + i]    = 1'b1;
        line_tag_q[base + i] = tg;
        return OUT_FILL;
      end
    end
    victim = 0;
    best   = age_rank[base];
    for (i = 1; i < nways; i++) begin
      if (age_rank[base + i] > best) begin
        best   = age_rank[base + i];
        victim = i;
      end
    end
    if (evict_total != '1) evict_total++;
    make_recent(base, nways, victim, 1'b1);
    line_tag_q[base + victim] = tg;
    return OUT_EVICT;
  endfunction

  function automatic void predict_access(op_e op, logic [31:0] a);
    access_report_t rep;
    if (op == OP_FETCH) begin
      fetch_count++;
      return;
    end
    rep.outcome = cache_access(a);
    if (op == OP_MODIFY) void'(cache_access(a));
    rep.second = (op == OP_MODIFY);
    rep.hits   = hit_total;
    rep.misses = miss_total;
    rep.evicts = evict_total;
    case (rep.outcome)
      OUT_HIT:  hit_outcomes++;
      OUT_FILL: fill_count++;
      default:  evict_count++;
    endcase
    expected_reports.push_back(rep);
  endfunction

  function automatic void queue_access(op_e op, logic [31:0] a);
    access_t item;
    item.op   = op;
    item.addr = a;
    pending_accesses.push_back(item);
    queued_count++;
  endfunction

  task automatic wait_drained();
    while (sent_count != queued_count || expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // leave cfg_valid_i high on return; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SET_BITS: raw_set_bits = val[3:0];
      CFG_OFF_BITS: raw_off_bits = val;
      CFG_WAYS:     raw_ways     = val[3:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_access(opcode_i, address_i);
        sent_count++;
        send_gap = pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          next_access = pending_accesses.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= next_access.op;
          address_i  <= next_access.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got_report.outcome = outcome_o;
        got_report.second  = second_hit_o;
        got_report.hits    = hits_total_o;
        got_report.misses  = misses_total_o;
        got_report.evicts  = evictions_total_o;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result with no access pending", $realtime);
        end else begin
          want_report = expected_reports.pop_front();
          if (got_report !== want_report) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch (expected/actual) outcome %0d/%0d second %0d/%0d",
                       $realtime, want_report.outcome, got_report.outcome,
                       want_report.second, got_report.second);
              $display("  hits %0d/%0d misses %0d/%0d evictions %0d/%0d",
                       want_report.hits, got_report.hits, want_report.misses,
                       got_report.misses, want_report.evicts, got_report.evicts);
            end
          end
        end
      end
      // hold off once for a long stretch so the tracker backs up
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held_once && results_seen >= 400 && pending_accesses.size() > 40) begin
        held_once      = 1'b1;
        long_hold_left = LONG_HOLD;
        out_ready_i    <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        gap_draw = pick_gap();
        if (gap_draw == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left  = gap_draw - 1;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
      $display("lru_set_assoc_cache_tracker_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned ph, made, r, s, b, w, tag_base;
    int unsigned set_pool[3];
    logic [31:0] addr, tg;
    op_e         op;

    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_SET_BITS;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_FETCH;
    address_i    = '0;
    out_ready_i  = 1'b0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    held_once    = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      line_ok[i]    = 1'b0;
      line_tag_q[i] = '0;
      age_rank[i]   = 0;
    end
    hit_total    = '0;
    miss_total   = '0;
    evict_total  = '0;
    raw_set_bits = SET_BITS_RST;
    raw_off_bits = OFF_BITS_RST;
    raw_ways     = WAYS_RST;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one way per set: fill, hits of every kind, evictions, fetches, address extremes
    queue_access(OP_LOAD,   32'h0000_0000);
    queue_access(OP_LOAD,   32'h0000_000F);
    queue_access(OP_STORE,  32'h0000_0008);
    queue_access(OP_MODIFY, 32'h0000_0004);
    queue_access(OP_FETCH,  32'h0000_1000);
    queue_access(OP_LOAD,   32'h0000_0100);
    queue_access(OP_MODIFY, 32'h0000_0000);
    queue_access(OP_STORE,  32'hFFFF_FFFF);
    queue_access(OP_LOAD,   32'hFFFF_FFF0);
    queue_access(OP_MODIFY, 32'h8000_00F0);
    queue_access(OP_FETCH,  32'hFFFF_FFFF);
    wait_drained();

    // four ways with a line already resident: fill the rest, then evict in LRU order
    write_reg(CFG_WAYS, 5'd4);
    cfg_valid_i <= 1'b0;
    settings_count++;
    queue_access(OP_LOAD,   32'h0000_0100);
    queue_access(OP_LOAD,   32'h0000_0200);
    queue_access(OP_LOAD,   32'h0000_0300);
    queue_access(OP_LOAD,   32'h0000_0400);
    queue_access(OP_LOAD,   32'h0000_0100);
    queue_access(OP_STORE,  32'h0000_0500);
    queue_access(OP_MODIFY, 32'h0000_0000);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph >= PHASES - 2) begin
        phase_cfg[ph][0] = $urandom_range(0, 15);
        phase_cfg[ph][1] = $urandom_range(0, 31);
        phase_cfg[ph][2] = $urandom_range(0, 15);
      end
      write_reg(CFG_SET_BITS, CFG_DATA_W'(phase_cfg[ph][0]));
      write_reg(CFG_OFF_BITS, CFG_DATA_W'(phase_cfg[ph][1]));
      write_reg(CFG_WAYS,     CFG_DATA_W'(phase_cfg[ph][2]));
      if (ph == 2) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
      cfg_valid_i <= 1'b0;
      settings_count++;
      no_idle <= (ph % 3 == 1);

      s = clamp_cfg(32'(raw_set_bits), 1, SET_BITS_MAX);
      b = clamp_cfg(32'(raw_off_bits), 1, OFFSET_MAX);
      w = clamp_cfg(32'(raw_ways), 1, WAYS_MAX);
      tag_base = $urandom;
      for (int k = 0; k < 3; k++) set_pool[k] = $urandom_range(0, (1 << s) - 1);
      made = 0;
      while (made < PHASE_ACCESSES) begin
        r  = $urandom_range(0, 99);
        op = op_e'($urandom_range(0, 3));
        if (r < 8) begin
          addr = $urandom;
        end else begin
          tg   = tag_base + $urandom_range(0, w + 1);
          addr = (tg << (b + s)) | (set_pool[$urandom_range(0, 2)] << b) |
                 ($urandom & ((32'd1 << b) - 1));
        end
        queue_access(op, addr);
        made++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (expected_reports.size() != 0) fail_count += expected_reports.size();
    $display("%0d accesses sent over %0d geometries, %0d results checked, %0d fetches",
             sent_count, settings_count, results_seen, fetch_count);
    $display("load outcomes: %0d hits, %0d fills, %0d evictions; %0d failures",
             hit_outcomes, fill_count, evict_count, fail_count);
    if (fail_count == 0) begin
      $display("lru_set_assoc_cache_tracker_tb: clean");
    end else begin
      $display("lru_set_assoc_cache_tracker_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lct_pkg.sv
hw/rtl/lct_set_ram.sv
hw/rtl/lct_update.sv
hw/rtl/lru_set_assoc_cache_tracker.sv
tb/sv/lru_set_assoc_cache_tracker_tb.sv
